[hdl/search_request_deframer_macros.svh]
// Assertion macros shared by the search request deframer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SEARCH_REQUEST_DEFRAMER_MACROS_SVH
`define SEARCH_REQUEST_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRD_ASSERT_IMP(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SRD_ASSERT_NXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/srd_pkg.sv]
// Package for the search request deframer: result kinds, header byte positions,
// queue sizing and the structs passed between the parser and the result queue.
`default_nettype none

package srd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // Header byte positions that carry fields; the rest are ignored.
  localparam int          HDR_POS_W   = 4;
  localparam logic [3:0]  HDR_CMD_HI  = 4'd0;
  localparam logic [3:0]  HDR_CMD_LO  = 4'd1;
  localparam logic [3:0]  HDR_LEN_HI  = 4'd2;
  localparam logic [3:0]  HDR_LEN_LO  = 4'd3;
  localparam logic [3:0]  HDR_ID_B3   = 4'd8;
  localparam logic [3:0]  HDR_ID_B2   = 4'd9;
  localparam logic [3:0]  HDR_ID_B1   = 4'd10;
  localparam logic [3:0]  HDR_ID_B0   = 4'd11;
  localparam logic [3:0]  HDR_LAST    = 4'd15;

  // Reset value of the search command register.
  localparam logic [15:0] SEARCH_CODE_RESET = 16'h0006;

  // Result queue sizing; depth must be a power of two, at least 4.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [15:0] byte_offset;
    logic [31:0] channel_id;
    logic [15:0] name_length;
    logic        last;
  } srd_result_t;

  // Up to two result words produced by one input word, in order.
  typedef struct packed {
    logic        v0;
    logic        v1;
    srd_result_t r0;
    srd_result_t r1;
  } srd_push_t;

endpackage

`default_nettype wire

[hdl/srd_parser.sv]
// Record parser: header collection, payload tracking and result generation.
// Depends on srd_pkg and the assertion macros header.
`default_nettype none
`include "search_request_deframer_macros.svh"

module srd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              datagram_end,
  input  wire logic              cfg_write,
  input  wire logic [15:0]       cfg_data,
  output srd_pkg::srd_push_t     push
);
  import srd_pkg::*;

  // Record state.
  logic [HDR_POS_W-1:0] hdr_pos, hdr_pos_next;
  logic [15:0]          hdr_cmd, hdr_cmd_next;
  logic [15:0]          pay_len, pay_len_next;
  logic [31:0]          chan_id, chan_id_next;
  logic [15:0]          pay_cnt, pay_cnt_next;
  logic [15:0]          strip_len, strip_len_next;
  logic                 in_payload, in_payload_next;
  logic                 is_search, is_search_next;
  logic [15:0]          search_code;

  // Per-word results before packing.
  logic                 name_v;
  logic                 tail_v;
  logic [1:0]           tail_kind;
  logic                 hit;
  srd_result_t          name_res;
  srd_result_t          tail_res;

  // Next-state and result computation for the word at the input.
  always_comb begin
    hdr_pos_next    = hdr_pos;
    hdr_cmd_next    = hdr_cmd;
    pay_len_next    = pay_len;
    chan_id_next    = chan_id;
    pay_cnt_next    = pay_cnt;
    strip_len_next  = strip_len;
    in_payload_next = in_payload;
    is_search_next  = is_search;
    name_v          = 1'b0;
    tail_v          = 1'b0;
    tail_kind       = KIND_DONE;
    hit             = 1'b0;

    if (!in_payload) begin
      unique case (hdr_pos)
        HDR_CMD_HI: hdr_cmd_next[15:8]  = data_byte;
        HDR_CMD_LO: hdr_cmd_next[7:0]   = data_byte;
        HDR_LEN_HI: pay_len_next[15:8]  = data_byte;
        HDR_LEN_LO: pay_len_next[7:0]   = data_byte;
        HDR_ID_B3:  chan_id_next[31:24] = data_byte;
        HDR_ID_B2:  chan_id_next[23:16] = data_byte;
        HDR_ID_B1:  chan_id_next[15:8]  = data_byte;
        HDR_ID_B0:  chan_id_next[7:0]   = data_byte;
        default: ;
      endcase
      if (hdr_pos == HDR_LAST) begin
        hit            = (hdr_cmd_next == search_code);
        hdr_pos_next   = '0;
        pay_cnt_next   = '0;
        strip_len_next = '0;
        if (pay_len_next == 16'd0) begin
          // An empty search payload completes on the last header byte.
          tail_v          = hit;
          tail_kind       = KIND_DONE;
          in_payload_next = 1'b0;
          is_search_next  = 1'b0;
        end else begin
          in_payload_next = 1'b1;
          is_search_next  = hit;
        end
      end else begin
        hdr_pos_next = hdr_pos + 1'b1;
      end
    end else begin
      if (is_search) begin
        name_v = 1'b1;
        if (data_byte != 8'd0) begin
          strip_len_next = pay_cnt + 16'd1;
        end
      end
      pay_cnt_next = pay_cnt + 16'd1;
      if (pay_cnt_next >= pay_len) begin
        tail_v          = is_search;
        tail_kind       = KIND_DONE;
        in_payload_next = 1'b0;
        is_search_next  = 1'b0;
        pay_cnt_next    = '0;
      end
    end

    // End of datagram: report a cut search payload, then drop all record state.
    if (datagram_end) begin
      if (in_payload_next && is_search_next) begin
        tail_v    = 1'b1;
        tail_kind = KIND_TRUNC;
      end
    end

    name_res             = '0;
    name_res.kind        = KIND_NAME;
    name_res.name_byte   = data_byte;
    name_res.byte_offset = pay_cnt;

    tail_res             = '0;
    tail_res.kind        = tail_kind;
    tail_res.channel_id  = chan_id_next;
    tail_res.name_length = strip_len_next;
    tail_res.last        = 1'b1;

    if (!in_payload_next) begin
      strip_len_next = '0;
    end

    if (datagram_end) begin
      hdr_pos_next    = '0;
      hdr_cmd_next    = '0;
      pay_len_next    = '0;
      chan_id_next    = '0;
      pay_cnt_next    = '0;
      strip_len_next  = '0;
      in_payload_next = 1'b0;
      is_search_next  = 1'b0;
    end

    // Pack in order: the name byte first, then the record end.
    push.v0       = name_v | tail_v;
    push.v1       = name_v & tail_v;
    push.r0       = name_v ? name_res : tail_res;
    push.r0.last  = ~(name_v & tail_v);
    push.r1       = tail_res;
  end

  // State registers, advanced on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos    <= '0;
      hdr_cmd    <= '0;
      pay_len    <= '0;
      chan_id    <= '0;
      pay_cnt    <= '0;
      strip_len  <= '0;
      in_payload <= 1'b0;
      is_search  <= 1'b0;
    end else if (accept) begin
      hdr_pos    <= hdr_pos_next;
      hdr_cmd    <= hdr_cmd_next;
      pay_len    <= pay_len_next;
      chan_id    <= chan_id_next;
      pay_cnt    <= pay_cnt_next;
      strip_len  <= strip_len_next;
      in_payload <= in_payload_next;
      is_search  <= is_search_next;
    end
  end

  // Search command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_code <= SEARCH_CODE_RESET;
    end else if (cfg_write) begin
      search_code <= cfg_data;
    end
  end

  `SRD_ASSERT_IMP(a_pair_ordered, clk, rst, push.v1, push.v0, "second result without first")
  `SRD_ASSERT_IMP(a_pair_tail, clk, rst, push.v1, push.r1.kind != KIND_NAME && push.r0.kind == KIND_NAME, "result pair out of order")
  `SRD_ASSERT_NXT(a_end_clears, clk, rst, accept && datagram_end, !in_payload && hdr_pos == '0, "record state kept past datagram end")

endmodule

`default_nettype wire

[hdl/srd_result_queue.sv]
// Result queue: takes up to two result words per cycle, hands out one while rd_stall is low.
// Depends on srd_pkg and the assertion macros header.
`default_nettype none
`include "search_request_deframer_macros.svh"

module srd_result_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire srd_pkg::srd_push_t   push,
  output logic                      full,
  output logic                      rd_valid,
  input  wire logic                 rd_stall,
  output srd_pkg::srd_result_t      rd_data
);
  import srd_pkg::*;

  srd_result_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic [1:0]          push_n;
  logic                pop;

  // Room check leaves space for a full pair of results.
  assign full     = count > QCNT_W'(QUEUE_DEPTH - 2);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign pop      = rd_valid & ~rd_stall;

  always_comb begin
    push_n = '0;
    if (wr_en) begin
      push_n = {1'b0, push.v0} + {1'b0, push.v1};
    end
    count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  // Entry storage; the second word of a pair goes one place after the first.
  always_ff @(posedge clk) begin
    if (wr_en && push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (wr_en && push.v1) begin
      mem[wr_ptr + 1'b1] <= push.r1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  `SRD_ASSERT_IMP(a_no_overflow, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `SRD_ASSERT_IMP(a_pair_room, clk, rst, push_n == 2'd2, count <= QCNT_W'(QUEUE_DEPTH - 2), "pair written without room")
  `SRD_ASSERT_NXT(a_rd_advance, clk, rst, pop, rd_ptr == $past(rd_ptr) + 1'b1, "read pointer did not advance")

endmodule

`default_nettype wire

[hdl/search_request_deframer.sv]
// Search request deframer top level: parser feeding a small result queue.
// Depends on srd_pkg, srd_parser and srd_result_queue.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   in       | input     | in_valid / in_stall  | data_byte, datagram_end
//   out      | output    | out_valid / out_stall| kind, name_byte, byte_offset,
//            |           |                      | channel_id, name_length, last
//   cfg      | input     | cfg_write            | cfg_data (search command code)
//
// Each input word is parsed in the cycle it is accepted; its results are
// registered in a four-entry queue and reach the output behind earlier entries.
// Input runs at one word per cycle while out_stall is low and each word yields
// at most one result; two results from one word leave the single output port
// one after the other. in_stall rises when the queue lacks room for two results;
// out_stall only holds the queue. Reset is synchronous and resets parser and queue.
`default_nettype none

module search_request_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        datagram_end,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       name_byte,
  output logic [15:0]      byte_offset,
  output logic [31:0]      channel_id,
  output logic [15:0]      name_length,
  output logic             last
);
  import srd_pkg::*;

  logic        accept;
  logic        full;
  srd_push_t   push;
  srd_result_t head;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  // Header and payload parsing.
  srd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .datagram_end (datagram_end),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push)
  );

  // Result buffering toward the output channel.
  srd_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .push     (push),
    .full     (full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (head)
  );

  // Output fields from the queue head.
  assign kind        = head.kind;
  assign name_byte   = head.name_byte;
  assign byte_offset = head.byte_offset;
  assign channel_id  = head.channel_id;
  assign name_length = head.name_length;
  assign last        = head.last;

endmodule

`default_nettype wire
